FILE: rtl/core/sit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants for the sorted interval table
// Transaction payloads, command and status codes, cell row bus types.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int DEF_CAPACITY = 16;

  localparam int CMD_W       = 2;
  localparam int TIME_W      = 12;
  localparam int ROOM_W      = 16;
  localparam int STATUS_W    = 3;
  localparam int POS_W       = 4;
  localparam int OUT_COUNT_W = 5;
  // wide enough for any slot index up to the largest supported capacity
  localparam int SLOT_W      = 9;

  localparam logic [TIME_W-1:0] DAY_END = TIME_W'(24 * 100);

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERLAP   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  localparam logic [1:0] SH_NONE = 2'd0;
  localparam logic [1:0] SH_INS  = 2'd1;
  localparam logic [1:0] SH_REM  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] begin_time;
    logic [TIME_W-1:0] end_time;
    logic [ROOM_W-1:0] room;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [POS_W-1:0]       position;
    logic [TIME_W-1:0]      found_end;
    logic [ROOM_W-1:0]      found_room;
    logic [OUT_COUNT_W-1:0] count;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] begin_time;
    logic [TIME_W-1:0] end_time;
    logic [ROOM_W-1:0] room;
  } entry_t;

  // search state handed from cell to cell
  typedef struct packed {
    logic              ins;
    logic [TIME_W-1:0] key;
    logic [TIME_W-1:0] lim;
    logic              hit;
    logic              ovl;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] f_end;
    logic [ROOM_W-1:0] f_room;
  } scan_bus_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] pos;
    logic [SLOT_W-1:0] count;
    entry_t            fill;
  } cell_ctl_t;

endpackage

FILE: rtl/core/sit_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_cell: one table slot of the sorted interval table
// Holds one entry, evaluates the passing search and shifts on insert/remove.
// ----------------------------------------------------------------------------
module sit_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  sit_pkg::cell_ctl_t ctl,
  input  sit_pkg::entry_t    prev_ent,
  input  sit_pkg::entry_t    next_ent,
  output sit_pkg::entry_t    ent,
  input  sit_pkg::scan_bus_t bus_in,
  output sit_pkg::scan_bus_t bus_out
);
  import sit_pkg::*;

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);
  localparam logic [SLOT_W-1:0] NX_SLOT = SLOT_W'(IDX + 1);
  localparam bit IS_HEAD = (IDX == 0);

  entry_t    ent_r, ent_nxt;
  scan_bus_t bus_r, bus_nxt;
  logic      valid_me, valid_nx;

  assign valid_me = MY_SLOT < ctl.count;
  assign valid_nx = NX_SLOT < ctl.count;

  always_comb begin
    bus_nxt = bus_in;
    if (!bus_in.hit) begin
      if (bus_in.ins) begin
        if (IS_HEAD && !valid_me) begin
          bus_nxt.hit  = 1'b1;
          bus_nxt.slot = MY_SLOT;
        end else if (IS_HEAD && bus_in.key < ent_r.begin_time) begin
          bus_nxt.hit  = 1'b1;
          bus_nxt.ovl  = bus_in.lim > ent_r.begin_time;
          bus_nxt.slot = MY_SLOT;
        end else if (valid_me && valid_nx && bus_in.key >= ent_r.end_time &&
                     bus_in.lim <= next_ent.begin_time) begin
          bus_nxt.hit  = 1'b1;
          bus_nxt.slot = NX_SLOT;
        end else if (valid_me && !valid_nx) begin
          bus_nxt.hit  = 1'b1;
          bus_nxt.ovl  = bus_in.key < ent_r.end_time;
          bus_nxt.slot = NX_SLOT;
        end
      end else if (valid_me && ent_r.begin_time == bus_in.key) begin
        bus_nxt.hit    = 1'b1;
        bus_nxt.slot   = MY_SLOT;
        bus_nxt.f_end  = ent_r.end_time;
        bus_nxt.f_room = ent_r.room;
      end
    end
  end

  always_comb begin
    ent_nxt = ent_r;
    case (ctl.op)
      SH_INS: begin
        if (MY_SLOT > ctl.pos) begin
          ent_nxt = prev_ent;
        end else if (MY_SLOT == ctl.pos) begin
          ent_nxt = ctl.fill;
        end
      end
      SH_REM: begin
        if (MY_SLOT >= ctl.pos) begin
          ent_nxt = next_ent;
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    bus_r <= bus_nxt;
  end

  assign ent     = ent_r;
  assign bus_out = bus_r;

endmodule

FILE: rtl/core/sorted_interval_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_interval_table: sorted table of non-overlapping intervals
// Insert, remove and find on a row of entry cells with a shared sequencer.
// ----------------------------------------------------------------------------
// Once a transaction is accepted, the search travels down the row of cells
// one cell per cycle; then, in the decide state, the result is decided, the
// whole row shifts at once and the result goes to the output register. The
// next command can be accepted in the idle state that follows. One command is
// handled at a time; in_stall is low only between commands. A finished result
// sits in the output register, and the next command may be accepted while it
// waits; that command holds in its decide state until the output register is
// free. Stored entries are undefined until written; only entries below the
// current count are ever looked at.
// ----------------------------------------------------------------------------
module sorted_interval_table #(
  parameter int CAPACITY = sit_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sit_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sit_pkg::out_item_t  out_data
);
  import sit_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SCAN_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(CAPACITY - 1);
  localparam logic [SCAN_W-1:0] SCAN_ONE  = SCAN_W'(1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [SCAN_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt, count_after;
  in_item_t          req_r;
  logic              out_vld_r;
  out_item_t         out_r, res;
  logic [1:0]        op_sel;
  logic              proceed, in_take;

  cell_ctl_t ctl;
  scan_bus_t head_bus, tail_bus;
  scan_bus_t buses [CAPACITY];
  entry_t    ents [CAPACITY];
  entry_t    prev_ents [CAPACITY];
  entry_t    next_ents [CAPACITY];

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign proceed  = (state_r == S_DECIDE) && (!out_vld_r || !out_stall);

  always_comb begin
    head_bus        = '0;
    head_bus.ins    = (req_r.cmd == CMD_INSERT);
    head_bus.key    = req_r.begin_time;
    head_bus.lim    = req_r.end_time;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign prev_ents[g] = ents[g];
      end else begin : g_mid
        assign prev_ents[g] = ents[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign next_ents[g] = ents[g];
      end else begin : g_body
        assign next_ents[g] = ents[g+1];
      end
      if (g == 0) begin : g_first
        sit_cell #(.IDX(g)) u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .prev_ent (prev_ents[g]),
          .next_ent (next_ents[g]),
          .ent      (ents[g]),
          .bus_in   (head_bus),
          .bus_out  (buses[g])
        );
      end else begin : g_rest
        sit_cell #(.IDX(g)) u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .prev_ent (prev_ents[g]),
          .next_ent (next_ents[g]),
          .ent      (ents[g]),
          .bus_in   (buses[g-1]),
          .bus_out  (buses[g])
        );
      end
    end
  endgenerate

  assign tail_bus = buses[CAPACITY-1];

  always_comb begin
    res         = '0;
    op_sel      = SH_NONE;
    count_after = count_r;
    case (req_r.cmd)
      CMD_INSERT: begin
        if (req_r.begin_time > DAY_END || req_r.end_time > DAY_END) begin
          res.status = ST_ILLEGAL;
        end else if (tail_bus.ovl) begin
          res.status = ST_OVERLAP;
        end else if (count_r >= CAP_CNT) begin
          res.status = ST_FULL;
        end else begin
          res.status   = ST_OK;
          res.position = tail_bus.slot[POS_W-1:0];
          op_sel       = SH_INS;
          count_after  = count_r + CNT_ONE;
        end
      end
      CMD_REMOVE: begin
        if (!tail_bus.hit) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.status   = ST_OK;
          res.position = tail_bus.slot[POS_W-1:0];
          op_sel       = SH_REM;
          count_after  = count_r - CNT_ONE;
        end
      end
      CMD_FIND: begin
        if (!tail_bus.hit) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.status     = ST_OK;
          res.position   = tail_bus.slot[POS_W-1:0];
          res.found_end  = tail_bus.f_end;
          res.found_room = tail_bus.f_room;
        end
      end
      default: res.status = ST_ILLEGAL;
    endcase
    res.count = OUT_COUNT_W'(count_after);
  end

  always_comb begin
    ctl.op    = proceed ? op_sel : SH_NONE;
    ctl.pos   = tail_bus.slot;
    ctl.count = SLOT_W'(count_r);
    ctl.fill  = '{begin_time: req_r.begin_time, end_time: req_r.end_time,
                  room: req_r.room};
  end

  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    count_nxt    = count_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt    = S_SCAN;
          scan_cnt_nxt = '0;
        end
      end
      S_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + SCAN_ONE;
        if (scan_cnt_r == SCAN_LAST) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (proceed) begin
          state_nxt = S_IDLE;
          count_nxt = count_after;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      scan_cnt_r <= '0;
      count_r    <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      count_r    <= count_nxt;
      if (proceed) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= in_data;
    end
    if (proceed) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == S_DECIDE))
    else $error("result raised outside decide");

  a_shift_only_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DECIDE) |-> (ctl.op == SH_NONE))
    else $error("row shift outside decide");

  a_insert_placed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && req_r.cmd == CMD_INSERT) |-> tail_bus.hit)
    else $error("insert search found no slot");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == SH_INS) |=> (count_r == $past(count_r) + CNT_ONE))
    else $error("insert did not grow table");

endmodule
